/* rtl/chr_pkg.sv */
// chr_pkg: shared types and codes of the consistent-hash ring lookup block
// no dependencies
package chr_pkg;

	localparam logic [2:0] KIND_INSERT  = 3'd0;
	localparam logic [2:0] KIND_REMOVE  = 3'd1;
	localparam logic [2:0] KIND_DROP    = 3'd2;
	localparam logic [2:0] KIND_LOOKUP  = 3'd3;
	localparam logic [2:0] KIND_BALANCE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ABSENT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_FEW      = 2'd3;

	localparam logic [7:0] THRESHOLD_RESET = 8'd64;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key_hash;
		logic [3:0]  node_id;
	} req_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] owner_node;
		logic       imbalanced;
	} rsp_word_t;

	typedef struct packed {
		logic [31:0] point;
		logic [3:0]  owner;
	} ring_entry_t;

endpackage

/* rtl/chr_req_if.sv */
// chr_req_if: valid/ready channel carrying one request word
// depends on chr_pkg
interface chr_req_if import chr_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/chr_rsp_if.sv */
// chr_rsp_if: valid/ready channel carrying one response word
// depends on chr_pkg
interface chr_rsp_if import chr_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/chr_ram.sv */
// chr_ram: generic single-write, single-read ram with registered read data
// no dependencies
module chr_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/consistent_hash_ring_lookup.sv */
// consistent_hash_ring_lookup: sorted hash ring with lookup, hit counting and balance check
// lookup: binary search, each probe reads one ring entry and compares its point
// insert/remove: search, then shift later entries by one; drop: compact the ring in one pass
// balance check: walks all node slots; one word in flight, result held in an output register
// reset clears fill, node flags, hit counters and sets threshold to 64; ring ram is not cleared
// depends on chr_pkg, chr_req_if, chr_rsp_if, chr_ram
module consistent_hash_ring_lookup import chr_pkg::*; #(
	parameter int RING_DEPTH  = 1024,
	parameter int NODE_SLOTS  = 16,
	parameter int MIN_SAMPLES = 1000
) (
	input  logic       clk,
	input  logic       arst_n,
	chr_req_if.sink    req,
	chr_rsp_if.source  rsp,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);
	localparam int AW  = $clog2(RING_DEPTH);
	localparam int FW  = AW + 1;
	localparam int NW  = (NODE_SLOTS > 2) ? $clog2(NODE_SLOTS) : 1;
	localparam int NCW = $clog2(NODE_SLOTS + 1);
	localparam int SW  = 32 + NCW;
	localparam int CW  = SW + 8;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SRCH    = 4'd1;
	localparam logic [3:0] S_SCMP    = 4'd2;
	localparam logic [3:0] S_POS_RD  = 4'd3;
	localparam logic [3:0] S_POS_CHK = 4'd4;
	localparam logic [3:0] S_SHU_RD  = 4'd5;
	localparam logic [3:0] S_SHU_WR  = 4'd6;
	localparam logic [3:0] S_SHD_RD  = 4'd7;
	localparam logic [3:0] S_SHD_WR  = 4'd8;
	localparam logic [3:0] S_DR_RD   = 4'd9;
	localparam logic [3:0] S_DR_WR   = 4'd10;
	localparam logic [3:0] S_BAL_CNT = 4'd11;
	localparam logic [3:0] S_BAL_MUL = 4'd12;
	localparam logic [3:0] S_BAL_CMP = 4'd13;
	localparam logic [3:0] S_DONE    = 4'd14;

	logic [3:0]      state_q;
	req_word_t       cur_q;
	logic [FW-1:0]   fill_q, lo_q, hi_q, idx_q, wr_q;
	logic [AW-1:0]   mid_q;
	logic [NODE_SLOTS-1:0] reg_q, cnt_q;
	logic [31:0]     hits_q [NODE_SLOTS];
	logic [31:0]     total_q;
	logic [7:0]      thr_q;
	rsp_word_t       res_q, rsp_q;
	logic            rsp_valid_q;
	logic [NCW-1:0]  n_q;
	logic [NW-1:0]   ni_q;
	logic [CW-1:0]   thr_tot_q;
	logic [SW-1:0]   scaled_s1;
	logic            counted_s1;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	ring_entry_t     ram_wdata, ram_rdata;

	logic [FW:0]     mid_sum;
	logic            node_ok, found;
	logic [NW-1:0]   req_ni, own_ni;
	logic [NCW-1:0]  popcnt;
	logic [SW-1:0]   tot_ext, dev;
	logic [CW-1:0]   dev_sh;
	rsp_word_t       start_res;
	logic [3:0]      start_state;

	chr_ram #(.WIDTH($bits(ring_entry_t)), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign node_ok = (32'(cur_q.node_id) < 32'(NODE_SLOTS));
	assign found   = (lo_q < fill_q) && (ram_rdata.point == cur_q.key_hash);
	assign req_ni  = NW'(cur_q.node_id);
	assign own_ni  = NW'(ram_rdata.owner);
	assign tot_ext = SW'(total_q);
	assign dev     = (scaled_s1 > tot_ext) ? scaled_s1 - tot_ext : tot_ext - scaled_s1;
	assign dev_sh  = {dev, 8'd0};

	always_comb begin
		popcnt = '0;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			popcnt = popcnt + NCW'(reg_q[i]);
		end
	end

	// first state and early result of an accepted word
	always_comb begin
		start_res   = '0;
		start_state = S_DONE;
		case (req.data.kind)
			KIND_INSERT: begin
				if (32'(req.data.node_id) < 32'(NODE_SLOTS)) begin
					start_state = S_SRCH;
				end else begin
					start_res.status = ST_ABSENT;
				end
			end
			KIND_REMOVE: begin
				start_state = S_SRCH;
			end
			KIND_LOOKUP: begin
				if (fill_q == '0) begin
					start_res.status = ST_ABSENT;
				end else begin
					start_state = S_SRCH;
				end
			end
			KIND_DROP: begin
				start_state = S_DR_RD;
			end
			KIND_BALANCE: begin
				if (total_q < 32'(MIN_SAMPLES)) begin
					start_res.status = ST_FEW;
				end else begin
					start_state = S_BAL_CNT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(lo_q);
		ram_wdata = '{point: cur_q.key_hash, owner: cur_q.node_id};
		ram_raddr = AW'(lo_q);
		case (state_q)
			S_SRCH: begin
				ram_raddr = AW'(mid_sum >> 1);
			end
			S_POS_RD: begin
				ram_raddr = (lo_q < fill_q) ? AW'(lo_q) : '0;
			end
			S_POS_CHK: begin
				ram_we = (cur_q.kind == KIND_INSERT) && found;
			end
			S_SHU_RD: begin
				ram_raddr = AW'(idx_q - FW'(1));
				ram_we    = (idx_q == lo_q);
			end
			S_SHU_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_wdata = ram_rdata;
			end
			S_SHD_RD: begin
				ram_raddr = AW'(idx_q + FW'(1));
			end
			S_SHD_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_wdata = ram_rdata;
			end
			S_DR_RD: begin
				ram_raddr = AW'(idx_q);
			end
			S_DR_WR: begin
				ram_we    = (ram_rdata.owner != cur_q.node_id);
				ram_waddr = AW'(wr_q);
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			reg_q       <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			thr_q       <= THRESHOLD_RESET;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NODE_SLOTS; i++) begin
				hits_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cur_q   <= req.data;
						res_q   <= start_res;
						lo_q    <= '0;
						hi_q    <= fill_q;
						idx_q   <= '0;
						wr_q    <= '0;
						state_q <= start_state;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= AW'(mid_sum >> 1);
						state_q <= S_SCMP;
					end else begin
						state_q <= S_POS_RD;
					end
				end
				S_SCMP: begin
					if (ram_rdata.point < cur_q.key_hash) begin
						lo_q <= FW'(mid_q) + FW'(1);
					end else begin
						hi_q <= FW'(mid_q);
					end
					state_q <= S_SRCH;
				end
				S_POS_RD: begin
					state_q <= S_POS_CHK;
				end
				S_POS_CHK: begin
					case (cur_q.kind)
						KIND_INSERT: begin
							if (found) begin
								reg_q[req_ni] <= 1'b1;
								cnt_q[req_ni] <= 1'b1;
								state_q       <= S_DONE;
							end else if (fill_q == FW'(RING_DEPTH)) begin
								res_q.status <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								idx_q   <= fill_q;
								state_q <= S_SHU_RD;
							end
						end
						KIND_REMOVE: begin
							if (found) begin
								idx_q   <= lo_q;
								state_q <= S_SHD_RD;
							end else begin
								res_q.status <= ST_ABSENT;
								state_q      <= S_DONE;
							end
						end
						default: begin
							res_q.owner_node <= ram_rdata.owner;
							cnt_q[own_ni]    <= 1'b1;
							if (hits_q[own_ni] != '1) begin
								hits_q[own_ni] <= hits_q[own_ni] + 32'd1;
							end
							if (total_q != '1) begin
								total_q <= total_q + 32'd1;
							end
							state_q <= S_DONE;
						end
					endcase
				end
				S_SHU_RD: begin
					if (idx_q == lo_q) begin
						fill_q        <= fill_q + FW'(1);
						reg_q[req_ni] <= 1'b1;
						cnt_q[req_ni] <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_SHU_WR;
					end
				end
				S_SHU_WR: begin
					idx_q   <= idx_q - FW'(1);
					state_q <= S_SHU_RD;
				end
				S_SHD_RD: begin
					if (idx_q + FW'(1) >= fill_q) begin
						fill_q  <= fill_q - FW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHD_WR;
					end
				end
				S_SHD_WR: begin
					idx_q   <= idx_q + FW'(1);
					state_q <= S_SHD_RD;
				end
				S_DR_RD: begin
					if (!node_ok || !reg_q[req_ni]) begin
						res_q.status <= ST_ABSENT;
						state_q      <= S_DONE;
					end else if (idx_q == fill_q) begin
						fill_q         <= wr_q;
						reg_q[req_ni]  <= 1'b0;
						cnt_q[req_ni]  <= 1'b0;
						hits_q[req_ni] <= '0;
						state_q        <= S_DONE;
					end else begin
						state_q <= S_DR_WR;
					end
				end
				S_DR_WR: begin
					if (ram_rdata.owner != cur_q.node_id) begin
						wr_q <= wr_q + FW'(1);
					end
					idx_q   <= idx_q + FW'(1);
					state_q <= S_DR_RD;
				end
				S_BAL_CNT: begin
					n_q       <= popcnt;
					ni_q      <= '0;
					thr_tot_q <= CW'(thr_q) * CW'(total_q);
					if (popcnt == '0) begin
						res_q.status <= ST_ABSENT;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_BAL_MUL;
					end
				end
				S_BAL_MUL: begin
					scaled_s1  <= SW'(hits_q[ni_q]) * SW'(n_q);
					counted_s1 <= cnt_q[ni_q];
					state_q    <= S_BAL_CMP;
				end
				S_BAL_CMP: begin
					if (counted_s1 && (dev_sh > thr_tot_q)) begin
						res_q.imbalanced <= 1'b1;
					end
					if (ni_q == NW'(NODE_SLOTS - 1)) begin
						state_q <= S_DONE;
					end else begin
						ni_q    <= ni_q + NW'(1);
						state_q <= S_BAL_MUL;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_DEPTH))
		else $error("ring fill above depth");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_SCMP) |-> (lo_q <= hi_q && hi_q <= fill_q))
		else $error("search bounds out of order");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= $past(total_q))
		else $error("total hits decreased");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DR_RD) |=> (fill_q == $past(fill_q) || fill_q == $past(fill_q) + FW'(1)
			|| fill_q == $past(fill_q) - FW'(1)))
		else $error("ring fill jumped outside a drop");
endmodule
